/* src/bcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types, register indexes and operation codes of the binary cross
// morphology block.
// ----------------------------------------------------------------------------
package bcm_pkg;

    localparam int ROW_BITS       = 64;
    localparam int WIDTH_BITS     = 7;
    localparam int MODE_BITS      = 2;
    localparam int OP_BITS        = 2;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;
    localparam int MAX_RESULTS    = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OPERATION_MODE = 4'd1;

    localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET    = 7'd64;

    // operation modes
    localparam logic [MODE_BITS-1:0] MODE_DILATION = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_EROSION  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_OPENING  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_CLOSING  = 2'd3;

    localparam logic [MODE_BITS-1:0] OPERATION_MODE_RESET = MODE_DILATION;

    // per-stage operation codes
    localparam logic [OP_BITS-1:0] OP_NONE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DIL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_ERO  = 2'd2;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_pixels;
        logic                final_row;
    } row_req_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] result_pixels;
        logic                frame_end;
        logic                frame_changed;
    } result_t;

    // what one cross operation is asked to do
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               has_up;
        logic               has_dn;
    } op_ctl_t;

    function automatic logic [OP_BITS-1:0] first_op(input logic [MODE_BITS-1:0] mode);
        logic [OP_BITS-1:0] op;
        unique case (mode)
            MODE_DILATION: op = OP_DIL;
            MODE_EROSION:  op = OP_ERO;
            MODE_OPENING:  op = OP_ERO;
            MODE_CLOSING:  op = OP_DIL;
        endcase
        return op;
    endfunction

    function automatic logic [OP_BITS-1:0] second_op(input logic [MODE_BITS-1:0] mode);
        logic [OP_BITS-1:0] op;
        unique case (mode)
            MODE_DILATION: op = OP_NONE;
            MODE_EROSION:  op = OP_NONE;
            MODE_OPENING:  op = OP_DIL;
            MODE_CLOSING:  op = OP_ERO;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

/* src/bcm_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcm_lane
// One pixel column of the cross operation: dilation, erosion or pass.
// ----------------------------------------------------------------------------
module bcm_lane
(
    input  bcm_pkg::op_ctl_t ctl,
    input  logic             cur,
    input  logic             left,
    input  logic             right,
    input  logic             up,
    input  logic             dn,
    input  logic             first,
    input  logic             last,
    input  logic             in_bounds,
    output logic             pix
);
    import bcm_pkg::*;

    logic r;

    always_comb
    begin
        unique case (ctl.op)
            OP_DIL:
            begin
                r = cur | left | right | (ctl.has_up & up) | (ctl.has_dn & dn);
            end
            OP_ERO:
            begin
                // missing left/right neighbours at the image edge count as set
                r = cur & (left | first) & (right | last)
                    & (~ctl.has_up | up) & (~ctl.has_dn | dn);
            end
            OP_NONE:
            begin
                r = cur;
            end
            default:
            begin
                r = cur;
            end
        endcase
    end

    assign pix = r & in_bounds;

endmodule
`default_nettype wire

/* src/bcm_cross_op.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcm_cross_op
// Row of lanes applying one cross operation to a row, plus the merge that
// tells whether any column changed.
// ----------------------------------------------------------------------------
module bcm_cross_op #(
    parameter int LANES = 64
)
(
    input  bcm_pkg::op_ctl_t                    ctl,
    input  logic [bcm_pkg::WIDTH_BITS-1:0]      eff_width,
    input  logic [LANES-1:0]                    cur,
    input  logic [LANES-1:0]                    up,
    input  logic [LANES-1:0]                    dn,
    output logic [LANES-1:0]                    res,
    output logic                                changed
);
    import bcm_pkg::*;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic left_pix;
        logic right_pix;

        if (i == 0)
        begin : g_left
            assign left_pix = 1'b0;
        end
        else
        begin : g_left
            assign left_pix = cur[i-1];
        end

        if (i == LANES - 1)
        begin : g_right
            assign right_pix = 1'b0;
        end
        else
        begin : g_right
            assign right_pix = cur[i+1];
        end

        bcm_lane u_lane
        (
            .ctl       (ctl),
            .cur       (cur[i]),
            .left      (left_pix),
            .right     (right_pix),
            .up        (up[i]),
            .dn        (dn[i]),
            .first     (i == 0),
            .last      (eff_width == WIDTH_BITS'(i + 1)),
            .in_bounds (WIDTH_BITS'(i) < eff_width),
            .pix       (res[i])
        );
    end

    // merge: any lane that differs from its input
    assign changed = |(res ^ cur);

endmodule
`default_nettype wire

/* src/bcm_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcm_out_fifo
// Result queue taking up to SLOTS results a cycle and giving one a cycle when pop is high.
// ----------------------------------------------------------------------------
module bcm_out_fifo #(
    parameter int DEPTH = 8,
    parameter int SLOTS = 3
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [SLOTS-1:0]                push_valid,
    input  bcm_pkg::result_t                push_data [SLOTS],
    input  logic                            pop,
    output bcm_pkg::result_t                head,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    import bcm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_idx [SLOTS];
    logic [CNT_W-1:0]   push_cnt;

    // valid slots are packed together in order
    always_comb
    begin
        push_cnt = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            wr_idx[k] = wr_ptr_reg + PTR_W'(push_cnt);
            push_cnt  = push_cnt + CNT_W'(push_valid[k]);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            if (push_valid[k])
            begin
                mem[wr_idx[k]] <= push_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire

/* src/binary_cross_morphology.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_cross_morphology
// Streaming binary morphology (dilation, erosion, opening, closing) with a
// four-neighbour cross over rows of up to MAX_WIDTH pixels.
// ----------------------------------------------------------------------------
// Rows enter one per cycle on the pixel_row request channel, top row first,
// the bottom row marked by final_row. Two cascaded stages each keep two rows;
// the first stage works in the cycle a row is taken, its results are
// registered, and the second stage works in the next cycle, writing its results
// into an 8-entry output queue. Every lane (one per column) evaluates the
// cross in a few gates, so a row is taken every cycle as long as the queue
// fill plus three places for the row in flight leaves room for three more;
// a result leaves the queue every cycle result_ready is high. Result row r
// comes out with input row r+2 (earlier at the bottom of the frame), and is
// first offered on result_valid once it has passed the register between the
// stages and been written into the output queue.
// The bottom row flushes both stages and releases up to three results, which
// leave the queue one per cycle. Out-of-image neighbours are ignored, pixels
// at or above image_width are zero, and image_width is clamped to 1 to
// MAX_WIDTH. The bottom result of a frame carries frame_changed, set when any
// stage changed any pixel in that frame. Configuration writes are taken
// every cycle and must only be made while no rows are in flight.
// ----------------------------------------------------------------------------
module binary_cross_morphology #(
    parameter int MAX_WIDTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // row requests
    input  logic                                row_valid,
    output logic                                row_ready,
    input  bcm_pkg::row_req_t                   pixel_row,
    // result requests
    output logic                                result_valid,
    input  logic                                result_ready,
    output bcm_pkg::result_t                    result_row,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bcm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import bcm_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [MODE_BITS-1:0]   operation_mode_reg;
    logic [WIDTH_BITS-1:0]  eff_width;
    logic [MAX_WIDTH-1:0]   width_mask;
    logic [OP_BITS-1:0]     op1;
    logic [OP_BITS-1:0]     op2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IMAGE_WIDTH_RESET;
            operation_mode_reg <= OPERATION_MODE_RESET;
        end
        else if (cfg_valid)
        begin
            // writes beyond the register list are dropped
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data[WIDTH_BITS-1:0];
            end
            else if (cfg_index == REG_OPERATION_MODE)
            begin
                operation_mode_reg <= cfg_data[MODE_BITS-1:0];
            end
        end
    end

    // clamp width to 1..MAX_WIDTH
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = WIDTH_BITS'(1);
        end
        else if (image_width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            eff_width = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_width = image_width_reg;
        end
    end

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_mask
        assign width_mask[i] = WIDTH_BITS'(i) < eff_width;
    end

    assign op1 = first_op(operation_mode_reg);
    assign op2 = second_op(operation_mode_reg);

    // ------------------------------------------------------------------
    // first stage: works in the accepting cycle
    // ------------------------------------------------------------------
    logic                   row_accept;
    logic [MAX_WIDTH-1:0]   row_in;
    logic                   fin_in;
    logic [MAX_WIDTH-1:0]   s1_old_reg;
    logic [MAX_WIDTH-1:0]   s1_new_reg;
    logic [1:0]             s1_held_reg;
    logic [MAX_WIDTH-1:0]   s1_old_next;
    logic [MAX_WIDTH-1:0]   s1_new_next;
    logic [1:0]             s1_held_next;
    logic                   s1_full;
    logic                   s1_two;
    op_ctl_t                s1a_ctl;
    op_ctl_t                s1b_ctl;
    logic [MAX_WIDTH-1:0]   s1a_cur;
    logic [MAX_WIDTH-1:0]   s1a_res;
    logic [MAX_WIDTH-1:0]   s1b_res;
    logic                   s1a_chg;
    logic                   s1b_chg;
    logic                   s1_e0;
    logic                   s1_e1;
    logic                   s1_fin0;
    logic                   s1_chg;

    assign row_accept = row_valid & row_ready;
    assign row_in     = pixel_row.row_pixels[MAX_WIDTH-1:0] & width_mask;
    assign fin_in     = pixel_row.final_row;

    // a held count of three acts as two
    assign s1_full = s1_held_reg != 2'd0;
    assign s1_two  = s1_held_reg[1];

    // lane row a: middle row (or a lone single-row frame)
    assign s1a_ctl = '{op: op1, has_up: s1_two, has_dn: s1_full};
    assign s1a_cur = s1_full ? s1_new_reg : row_in;
    // lane row b: bottom row on flush
    assign s1b_ctl = '{op: op1, has_up: 1'b1, has_dn: 1'b0};

    bcm_cross_op #(.LANES(MAX_WIDTH)) u_s1a
    (
        .ctl       (s1a_ctl),
        .eff_width (eff_width),
        .cur       (s1a_cur),
        .up        (s1_old_reg),
        .dn        (row_in),
        .res       (s1a_res),
        .changed   (s1a_chg)
    );

    bcm_cross_op #(.LANES(MAX_WIDTH)) u_s1b
    (
        .ctl       (s1b_ctl),
        .eff_width (eff_width),
        .cur       (row_in),
        .up        (s1_new_reg),
        .dn        (row_in),
        .res       (s1b_res),
        .changed   (s1b_chg)
    );

    assign s1_e0   = s1_full | fin_in;
    assign s1_fin0 = ~s1_full & fin_in;
    assign s1_e1   = s1_full & fin_in;
    assign s1_chg  = (s1_e0 & s1a_chg) | (s1_e1 & s1b_chg);

    always_comb
    begin
        s1_old_next  = s1_old_reg;
        s1_new_next  = s1_new_reg;
        s1_held_next = s1_held_reg;
        if (row_accept)
        begin
            if (!s1_full)
            begin
                if (!fin_in)
                begin
                    s1_new_next  = row_in;
                    s1_held_next = 2'd1;
                end
            end
            else if (fin_in)
            begin
                s1_held_next = 2'd0;
            end
            else
            begin
                s1_old_next  = s1_new_reg;
                s1_new_next  = row_in;
                s1_held_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_old_reg <= s1_old_next;
        s1_new_reg <= s1_new_next;
    end

    // ------------------------------------------------------------------
    // register between the stages
    // ------------------------------------------------------------------
    logic                   p1_valid_reg;
    logic                   p1_e0_reg;
    logic                   p1_e1_reg;
    logic                   p1_fin0_reg;
    logic                   p1_chg_reg;
    logic [MAX_WIDTH-1:0]   p1_row0_reg;
    logic [MAX_WIDTH-1:0]   p1_row1_reg;

    always_ff @(posedge clk)
    begin
        if (row_accept)
        begin
            p1_row0_reg <= s1a_res;
            p1_row1_reg <= s1b_res;
        end
    end

    // ------------------------------------------------------------------
    // second stage: up to two pushes from the first stage in one cycle
    // ------------------------------------------------------------------
    logic [MAX_WIDTH-1:0]   s2_old_reg;
    logic [MAX_WIDTH-1:0]   s2_new_reg;
    logic [1:0]             s2_held_reg;
    logic [MAX_WIDTH-1:0]   s2_old_next;
    logic [MAX_WIDTH-1:0]   s2_new_next;
    logic [1:0]             s2_held_next;
    logic                   any_change_reg;
    logic                   any_change_next;
    logic                   s2_full;
    logic                   s2_two;
    logic                   push_a;
    logic                   push_b;
    op_ctl_t                u1_ctl;
    op_ctl_t                u2_ctl;
    op_ctl_t                u3_ctl;
    logic [MAX_WIDTH-1:0]   u1_cur;
    logic [MAX_WIDTH-1:0]   u2_cur;
    logic [MAX_WIDTH-1:0]   u2_up;
    logic [MAX_WIDTH-1:0]   u1_res;
    logic [MAX_WIDTH-1:0]   u2_res;
    logic [MAX_WIDTH-1:0]   u3_res;
    logic                   u1_chg;
    logic                   u2_chg;
    logic                   u3_chg;
    logic                   v0;
    logic                   v1;
    logic                   v2;
    logic                   f0;
    logic                   s2_chg;
    logic                   fin_out;
    logic                   frame_flag;
    logic [MAX_RESULTS-1:0] slot_valid;
    result_t                slot_data [MAX_RESULTS];

    assign s2_full = s2_held_reg != 2'd0;
    assign s2_two  = s2_held_reg[1];
    assign push_a  = p1_valid_reg & p1_e0_reg;
    assign push_b  = p1_valid_reg & p1_e1_reg;

    // u1: held middle row against the first pushed row
    assign u1_ctl = '{op: op2, has_up: s2_two, has_dn: s2_full};
    assign u1_cur = s2_full ? s2_new_reg : p1_row0_reg;
    // u3: first pushed row against the second, when both arrive
    assign u3_ctl = '{op: op2, has_up: s2_full, has_dn: 1'b1};
    // u2: bottom row of the frame
    assign u2_ctl = '{op: op2, has_up: 1'b1, has_dn: 1'b0};
    assign u2_cur = p1_fin0_reg ? p1_row0_reg : p1_row1_reg;
    assign u2_up  = p1_fin0_reg ? s2_new_reg : p1_row0_reg;

    bcm_cross_op #(.LANES(MAX_WIDTH)) u_s2_u1
    (
        .ctl       (u1_ctl),
        .eff_width (eff_width),
        .cur       (u1_cur),
        .up        (s2_old_reg),
        .dn        (p1_row0_reg),
        .res       (u1_res),
        .changed   (u1_chg)
    );

    bcm_cross_op #(.LANES(MAX_WIDTH)) u_s2_u3
    (
        .ctl       (u3_ctl),
        .eff_width (eff_width),
        .cur       (p1_row0_reg),
        .up        (s2_new_reg),
        .dn        (p1_row1_reg),
        .res       (u3_res),
        .changed   (u3_chg)
    );

    bcm_cross_op #(.LANES(MAX_WIDTH)) u_s2_u2
    (
        .ctl       (u2_ctl),
        .eff_width (eff_width),
        .cur       (u2_cur),
        .up        (u2_up),
        .dn        (p1_row1_reg),
        .res       (u2_res),
        .changed   (u2_chg)
    );

    // results in order u1, u3, u2
    assign v0 = push_a & (s2_full | p1_fin0_reg);
    assign f0 = ~s2_full & p1_fin0_reg;
    assign v1 = push_b;
    assign v2 = (push_a & p1_fin0_reg & s2_full) | push_b;

    assign s2_chg     = (v0 & u1_chg) | (v1 & u3_chg) | (v2 & u2_chg);
    assign fin_out    = (v0 & f0) | v2;
    assign frame_flag = any_change_reg | (p1_valid_reg & p1_chg_reg) | s2_chg;

    assign slot_valid = {v2, v1, v0};

    always_comb
    begin
        slot_data[0] = '{result_pixels: ROW_BITS'(u1_res), frame_end: f0,
                         frame_changed: f0 & frame_flag};
        slot_data[1] = '{result_pixels: ROW_BITS'(u3_res), frame_end: 1'b0,
                         frame_changed: 1'b0};
        slot_data[2] = '{result_pixels: ROW_BITS'(u2_res), frame_end: 1'b1,
                         frame_changed: frame_flag};
    end

    always_comb
    begin
        s2_old_next     = s2_old_reg;
        s2_new_next     = s2_new_reg;
        s2_held_next    = s2_held_reg;
        any_change_next = any_change_reg;
        if (p1_valid_reg)
        begin
            any_change_next = fin_out ? 1'b0 : frame_flag;
        end
        if (push_a)
        begin
            if (p1_fin0_reg || push_b)
            begin
                s2_held_next = 2'd0;
            end
            else if (!s2_full)
            begin
                s2_new_next  = p1_row0_reg;
                s2_held_next = 2'd1;
            end
            else
            begin
                s2_old_next  = s2_new_reg;
                s2_new_next  = p1_row0_reg;
                s2_held_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_old_reg <= s2_old_next;
        s2_new_reg <= s2_new_next;
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_held_reg    <= 2'd0;
            s2_held_reg    <= 2'd0;
            any_change_reg <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_e0_reg      <= 1'b0;
            p1_e1_reg      <= 1'b0;
            p1_fin0_reg    <= 1'b0;
            p1_chg_reg     <= 1'b0;
        end
        else
        begin
            s1_held_reg    <= s1_held_next;
            s2_held_reg    <= s2_held_next;
            any_change_reg <= any_change_next;
            p1_valid_reg   <= row_accept;
            p1_e0_reg      <= row_accept & s1_e0;
            p1_e1_reg      <= row_accept & s1_e1;
            p1_fin0_reg    <= row_accept & s1_fin0;
            p1_chg_reg     <= row_accept & s1_chg;
        end
    end

    // ------------------------------------------------------------------
    // output queue and flow control
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   fifo_count;
    logic [CNT_W:0]     fifo_reserved;
    logic               result_pop;

    assign result_valid = fifo_count != '0;
    assign result_pop   = result_valid & result_ready;

    bcm_out_fifo #(.DEPTH(QUEUE_DEPTH), .SLOTS(MAX_RESULTS)) u_out_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (slot_valid),
        .push_data  (slot_data),
        .pop        (result_pop),
        .head       (result_row),
        .count      (fifo_count)
    );

    // room for the row in flight plus the one being taken
    assign fifo_reserved = (CNT_W + 1)'(fifo_count)
                         + (p1_valid_reg ? (CNT_W + 1)'(MAX_RESULTS) : '0);
    assign row_ready     = fifo_reserved <= (CNT_W + 1)'(QUEUE_DEPTH - MAX_RESULTS);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= CNT_W'(QUEUE_DEPTH))
        else $error("output queue overfilled");

    a_room_for_flight: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> fifo_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS))
        else $error("no room for results of the row in flight");

    a_changed_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_row.frame_changed |-> result_row.frame_end)
        else $error("frame_changed set on a row that is not the frame end");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_held_reg != 2'd3 && s2_held_reg != 2'd3)
        else $error("stage holds more than two rows");

endmodule
`default_nettype wire

/* tb/sv/binary_cross_morphology_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cross_morphology_test
// Self-checking bench for the streaming cross morphology block. A queue of
// row requests feeds a valid/ready driver, a bit-accurate two-stage model
// predicts each result row, and a monitor checks every result in order
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module binary_cross_morphology_test;

    import bcm_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ROWS     = 80;
    localparam int BLOCK_ROWS     = 18;
    localparam int PRESSURE_ROWS  = 60;

    // clock, reset and block inputs, all known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic row_valid = 1'b0;
    row_req_t pixel_row = '0;
    logic result_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic row_ready;
    logic result_valid;
    result_t result_row;
    logic cfg_ready;

    // stimulus and expected results
    row_req_t pending_rows[$];
    result_t expected_rows[$];

    // model copy of the registers and the two row stages
    logic [WIDTH_BITS-1:0] width_reg = IMAGE_WIDTH_RESET;
    logic [MODE_BITS-1:0] mode_reg = OPERATION_MODE_RESET;
    logic [ROW_BITS-1:0] stage_older[2];
    logic [ROW_BITS-1:0] stage_newer[2];
    int stage_held[2];
    bit change_seen;

    // idling controls, set per phase by the sequence below
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_req = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left = 0;

    int errors = 0;
    int rows_queued = 0;
    int rows_taken = 0;
    int frames_taken = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    binary_cross_morphology dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .pixel_row    (pixel_row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_row   (result_row),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // row prediction
    // ------------------------------------------------------------------------

    // one cross operation on a row, neighbours outside the image ignored
    function automatic logic [ROW_BITS-1:0] cross_op(
        input logic [OP_BITS-1:0] op,
        input logic [ROW_BITS-1:0] c,
        input bit has_up,
        input logic [ROW_BITS-1:0] up,
        input bit has_dn,
        input logic [ROW_BITS-1:0] dn,
        input int w,
        input logic [ROW_BITS-1:0] m
    );
        logic [ROW_BITS-1:0] r;
        logic [ROW_BITS-1:0] top;
        top = 64'd1 << (w - 1);
        if (op == OP_DIL)
        begin
            r = c | (c << 1) | (c >> 1);
            if (has_up) r = r | up;
            if (has_dn) r = r | dn;
        end
        else if (op == OP_ERO)
        begin
            // missing left or right neighbour counts as set
            r = c & ((c << 1) | 64'd1) & ((c >> 1) | top);
            if (has_up) r = r & up;
            if (has_dn) r = r & dn;
        end
        else
        begin
            r = c;
        end
        return r & m;
    endfunction

    // push one row into a stage, returning the rows it releases
    task automatic push_stage(
        input int s,
        input logic [OP_BITS-1:0] op,
        input logic [ROW_BITS-1:0] row,
        input bit fin,
        input int w,
        input logic [ROW_BITS-1:0] m,
        output int n,
        output logic [1:0][ROW_BITS-1:0] orow,
        output logic [1:0] ofin,
        inout bit chg
    );
        logic [ROW_BITS-1:0] r;
        n = 0;
        orow = '0;
        ofin = '0;
        if (stage_held[s] == 0)
        begin
            if (fin)
            begin
                // lone row of a frame, no vertical neighbours
                r = cross_op(op, row, 1'b0, '0, 1'b0, '0, w, m);
                if (r != row) chg = 1'b1;
                orow[n] = r;
                ofin[n] = 1'b1;
                n++;
            end
            else
            begin
                stage_newer[s] = row;
                stage_held[s] = 1;
            end
        end
        else
        begin
            r = cross_op(op, stage_newer[s], stage_held[s] == 2, stage_older[s],
                         1'b1, row, w, m);
            if (r != stage_newer[s]) chg = 1'b1;
            orow[n] = r;
            ofin[n] = 1'b0;
            n++;
            if (fin)
            begin
                // flush the bottom row as well
                r = cross_op(op, row, 1'b1, stage_newer[s], 1'b0, '0, w, m);
                if (r != row) chg = 1'b1;
                orow[n] = r;
                ofin[n] = 1'b1;
                n++;
                stage_held[s] = 0;
            end
            else
            begin
                stage_older[s] = stage_newer[s];
                stage_newer[s] = row;
                stage_held[s] = 2;
            end
        end
    endtask

    // work out every result released by one accepted row request
    task automatic predict_rows(input row_req_t req);
        int w;
        int n1;
        int n2;
        logic [ROW_BITS-1:0] m;
        logic [OP_BITS-1:0] op1;
        logic [OP_BITS-1:0] op2;
        logic [1:0][ROW_BITS-1:0] r1;
        logic [1:0][ROW_BITS-1:0] r2;
        logic [1:0] f1;
        logic [1:0] f2;
        bit chg;
        result_t res;
        // width is clamped to 1 to 64
        w = (width_reg == 0) ? 1 : ((width_reg > 64) ? 64 : int'(width_reg));
        m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        case (mode_reg)
            MODE_DILATION: begin op1 = OP_DIL; op2 = OP_NONE; end
            MODE_EROSION:  begin op1 = OP_ERO; op2 = OP_NONE; end
            MODE_OPENING:  begin op1 = OP_ERO; op2 = OP_DIL;  end
            default:       begin op1 = OP_DIL; op2 = OP_ERO;  end
        endcase
        chg = 1'b0;
        push_stage(0, op1, req.row_pixels & m, req.final_row, w, m, n1, r1, f1, chg);
        for (int k = 0; k < n1; k++)
        begin
            push_stage(1, op2, r1[k], f1[k], w, m, n2, r2, f2, chg);
            for (int j = 0; j < n2; j++)
            begin
                res.result_pixels = r2[j];
                res.frame_end = f2[j];
                res.frame_changed = 1'b0;
                if (f2[j])
                begin
                    res.frame_changed = change_seen | chg;
                    change_seen = 1'b0;
                    chg = 1'b0;
                end
                expected_rows.push_back(res);
            end
        end
        if (chg) change_seen = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // row request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid <= 1'b0;
            pixel_row <= '0;
        end
        else
        begin
            if (row_valid && row_ready)
            begin
                predict_rows(pixel_row);
                rows_taken++;
                if (pixel_row.final_row) frames_taken++;
            end
            // payload only moves once the current request is gone
            if (!row_valid || row_ready)
            begin
                if (pending_rows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pixel_row <= pending_rows.pop_front();
                    row_valid <= 1'b1;
                end
                else
                begin
                    row_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (expected_rows.size() == 0)
                begin
                    $display("%0t: result request with none expected, got %h",
                             $time, result_row);
                    errors++;
                end
                else
                begin
                    result_t exp_row;
                    exp_row = expected_rows.pop_front();
                    if (result_row.result_pixels !== exp_row.result_pixels)
                    begin
                        $display("%0t: result_pixels expected %h, got %h", $time,
                                 exp_row.result_pixels, result_row.result_pixels);
                        errors++;
                    end
                    if (result_row.frame_end !== exp_row.frame_end)
                    begin
                        $display("%0t: frame_end expected %b, got %b", $time,
                                 exp_row.frame_end, result_row.frame_end);
                        errors++;
                    end
                    if (result_row.frame_changed !== exp_row.frame_changed)
                    begin
                        $display("%0t: frame_changed expected %b, got %b", $time,
                                 exp_row.frame_changed, result_row.frame_changed);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block fills and backs up its input
            if (pressure_req && !pressure_done)
            begin
                hold_left = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on cycles with no request accepted anywhere
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (row_valid && row_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------------
    task automatic queue_row(input logic [ROW_BITS-1:0] row, input bit fin);
        pending_rows.push_back(row_req_t'{row_pixels: row, final_row: fin});
        rows_queued++;
    endtask

    // wait until every row is in and every result is out, then let it go quiet
    task automatic settle();
        while (pending_rows.size() != 0 || row_valid || expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_IMAGE_WIDTH)
            width_reg = data[WIDTH_BITS-1:0];
        else if (index == REG_OPERATION_MODE)
            mode_reg = data[MODE_BITS-1:0];
        reg_writes++;
    endtask

    // rows with a spread of densities, including empty and full
    function automatic logic [ROW_BITS-1:0] random_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        logic [ROW_BITS-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return a & b & c;
            3: return a | b;
            4: return ~(a & b & c);
            5: return a;
            default: return a & b;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int height;
        int block_count;
        int block_len;
        bit leave_open;
        logic [WIDTH_BITS-1:0] wv;

        for (int s = 0; s < 2; s++)
        begin
            stage_older[s] = '0;
            stage_newer[s] = '0;
            stage_held[s] = 0;
        end
        change_seen = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, full width dilation, edge columns
        queue_row(64'h8000_0000_0000_0001, 1'b1);
        queue_row(64'h0, 1'b0);
        queue_row(64'h0000_0001_0000_0000, 1'b0);
        queue_row(64'h0, 1'b1);
        settle();

        // erosion on a solid frame changes nothing, then a frame with a clear edge pixel
        write_reg(REG_OPERATION_MODE, {6'd0, MODE_EROSION});
        queue_row('1, 1'b0);
        queue_row('1, 1'b1);
        queue_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        queue_row('1, 1'b0);
        queue_row('1, 1'b1);
        settle();

        write_reg(REG_OPERATION_MODE, {6'd0, MODE_OPENING});
        queue_row(64'hF0F0_FFFF_0F0F_7E7E, 1'b0);
        queue_row(64'hFFFF_0FF0_FFFF_7E7E, 1'b0);
        queue_row(64'h0F0F_FFFF_F0F0_0000, 1'b1);
        settle();

        write_reg(REG_OPERATION_MODE, {6'd0, MODE_CLOSING});
        queue_row(64'hA5A5_5A5A_0000_FF00, 1'b0);
        queue_row(64'h5A5A_A5A5_8001_00FF, 1'b1);
        settle();

        // narrowest image, high data bit ignored
        write_reg(REG_IMAGE_WIDTH, 8'h81);
        queue_row('1, 1'b0);
        queue_row(64'h0, 1'b1);
        settle();

        // zero width clamps to one
        write_reg(REG_IMAGE_WIDTH, 8'h00);
        queue_row('1, 1'b1);
        settle();

        // oversized width clamps to the full row
        write_reg(REG_IMAGE_WIDTH, 8'h7F);
        queue_row(64'h8000_0000_0000_0001, 1'b0);
        queue_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
        queue_row(64'hC000_0000_0000_0003, 1'b1);
        settle();

        // mode switched while a frame is half way through
        write_reg(REG_IMAGE_WIDTH, 8'd64);
        write_reg(REG_OPERATION_MODE, {6'd0, MODE_DILATION});
        queue_row(64'h0000_0000_0001_0000, 1'b0);
        queue_row(64'h0000_FFFF_0000_0000, 1'b0);
        settle();
        write_reg(REG_OPERATION_MODE, {6'd0, MODE_EROSION});
        queue_row('1, 1'b0);
        queue_row(64'hFFFF_FFFF_0000_FFFF, 1'b1);
        settle();

        // random frames in four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            block_len = (phase == 0) ? PRESSURE_ROWS : BLOCK_ROWS;
            height = rows_queued + PHASE_ROWS;
            while (rows_queued < height)
            begin
                settle();
                // settings change only while idle, possibly inside a frame
                if ($urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 7))
                        0: wv = 7'd1;
                        1: wv = 7'd64;
                        2: wv = 7'd0;
                        3: wv = 7'($urandom_range(65, 127));
                        4: wv = 7'd2;
                        default: wv = 7'($urandom_range(1, 64));
                    endcase
                    write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), wv});
                end
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_OPERATION_MODE, {6'($urandom), 2'($urandom)});
                if ($urandom_range(0, 4) == 0)
                    write_reg(4'($urandom_range(2, 15)), 8'($urandom));

                block_count = 0;
                while (block_count < block_len)
                begin
                    int rows_in_frame;
                    rows_in_frame = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                               : $urandom_range(1, 6);
                    // now and then a frame is left open across a settings change
                    leave_open = ($urandom_range(0, 7) == 0);
                    for (int k = 0; k < rows_in_frame; k++)
                        queue_row(random_row(), (k == rows_in_frame - 1) && !leave_open);
                    block_count += rows_in_frame;
                end
                if (phase == 0) pressure_req = 1'b1;
                block_len = BLOCK_ROWS;
            end
        end

        // close any open frame so the stages drain
        queue_row(random_row(), 1'b1);
        settle();

        $display("covered %0d row requests in %0d frames, %0d results checked",
                 rows_taken, frames_taken, results_checked);
        $display("%0d register writes, idle, stall and long hold phases exercised",
                 reg_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
src/bcm_pkg.sv
src/bcm_lane.sv
src/bcm_cross_op.sv
src/bcm_out_fifo.sv
src/binary_cross_morphology.sv
tb/sv/binary_cross_morphology_test.sv
